### design/rc4_stream_cipher_macros.svh
// ----------------------------------------------------------------------------
// rc4 stream cipher assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// same-cycle implication
`define RC4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4 package
// widths, function codes, datapath operations and status shared by the block
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W          = 8;
  localparam int PERM_DEPTH      = 256;
  localparam int LEN_W           = 9;
  localparam int FUNC_W          = 2;
  localparam int MAX_KEY_LEN_DEF = 256;

  // request function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_KEY   = 2'd0,
    FUNC_BEGIN = 2'd1,
    FUNC_DATA  = 2'd2
  } rc4_func_e;

  // one datapath operation per cycle, issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_WR,
    OP_SCHED_START,
    OP_FILL,
    OP_KS_RD,
    OP_KS_J,
    OP_KS_WK,
    OP_KS_WJ,
    OP_D_RI,
    OP_D_J,
    OP_D_K,
    OP_D_W,
    OP_PASS_LATCH,
    OP_PASS_OUT
  } rc4_op_e;

  typedef struct packed {
    logic keyed;     // a key schedule has completed
    logic k_last;    // schedule counter at its final entry
    logic out_free;  // output register can take a result this cycle
  } rc4_status_t;

endpackage

### design/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4 controller
// sequences key writes, the key schedule and data bytes into datapath ops
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_macros.svh"

module rc4_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [rc4_pkg::FUNC_W-1:0]    func_i,
  output logic                          in_stall_o,
  input  rc4_pkg::rc4_status_t          sts_i,
  output rc4_pkg::rc4_op_e              op_o
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WK,
    ST_KS_WJ,
    ST_D_J,
    ST_D_K,
    ST_D_W,
    ST_PASS
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_KEY: begin
              op_o = OP_KEY_WR;
            end
            FUNC_BEGIN: begin
              op_o    = OP_SCHED_START;
              state_d = ST_FILL;
            end
            FUNC_DATA: begin
              if (sts_i.keyed) begin
                op_o    = OP_D_RI;
                state_d = ST_D_J;
              end else begin
                op_o    = OP_PASS_LATCH;
                state_d = ST_PASS;
              end
            end
            default: ;  // unused code, dropped
          endcase
        end
      end
      ST_FILL: begin
        op_o = OP_FILL;
        if (sts_i.k_last) state_d = ST_KS_RD;
      end
      ST_KS_RD: begin
        op_o    = OP_KS_RD;
        state_d = ST_KS_J;
      end
      ST_KS_J: begin
        op_o    = OP_KS_J;
        state_d = ST_KS_WK;
      end
      ST_KS_WK: begin
        op_o    = OP_KS_WK;
        state_d = ST_KS_WJ;
      end
      ST_KS_WJ: begin
        op_o    = OP_KS_WJ;
        state_d = sts_i.k_last ? ST_IDLE : ST_KS_RD;
      end
      ST_D_J: begin
        op_o    = OP_D_J;
        state_d = ST_D_K;
      end
      ST_D_K: begin
        op_o    = OP_D_K;
        state_d = ST_D_W;
      end
      ST_D_W: begin
        if (sts_i.out_free) begin
          op_o    = OP_D_W;
          state_d = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (sts_i.out_free) begin
          op_o    = OP_PASS_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `RC4_ASSERT_IMP(a_dw_needs_slot, op_o == OP_D_W || op_o == OP_PASS_OUT, sts_i.out_free, "result issued into a full output register")
  `RC4_ASSERT_NXT(a_sched_ends_idle, state_q == ST_KS_WJ && sts_i.k_last, state_q == ST_IDLE, "key schedule did not return to idle")
  `RC4_ASSERT_NXT(a_keyed_data_starts, in_valid_i && !in_stall_o && func_i == FUNC_DATA && sts_i.keyed, state_q == ST_D_J, "keyed data byte did not start the swap sequence")

endmodule

### design/rc4_datapath.sv
// ----------------------------------------------------------------------------
// rc4 datapath
// permutation and key memories, indices, key length and output register
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_macros.svh"

module rc4_datapath #(
  parameter int MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::LEN_W-1:0]     cfg_wdata_i,
  input  rc4_pkg::rc4_op_e              op_i,
  input  logic [rc4_pkg::BYTE_W-1:0]    key_index_i,
  input  logic [rc4_pkg::BYTE_W-1:0]    byte_in_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [rc4_pkg::BYTE_W-1:0]    byte_out_o,
  output logic                          not_keyed_o,
  output rc4_pkg::rc4_status_t          sts_o
);
  import rc4_pkg::*;

  localparam int KeyAw = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int PermAw = $clog2(PERM_DEPTH);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_KEY_LEN);
  localparam logic [PermAw-1:0] LastK = PermAw'(PERM_DEPTH - 1);

  // memories
  logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
  logic [BYTE_W-1:0] key_mem  [MAX_KEY_LEN];

  logic [BYTE_W-1:0] rd_a_q, rd_b_q, key_rd_q;

  // control state
  logic [LEN_W-1:0]  key_len_q;
  logic [PermAw-1:0] i_q, j_q, k_q;
  logic [KeyAw-1:0]  kpos_q;
  logic              keyed_q;
  logic              out_valid_q;

  // payload state
  logic [BYTE_W-1:0] data_q, s_q, sj_q, byte_out_q;
  logic [PermAw-1:0] t_q;
  logic              not_keyed_q;

  logic              pa_re, pb_re, pw_en;
  logic [PermAw-1:0] pa_addr, pb_addr, pw_addr;
  logic [BYTE_W-1:0] pw_data;
  logic [PermAw-1:0] jn, t;
  logic [BYTE_W-1:0] ks;
  logic              out_load, out_nk, out_free;
  logic [BYTE_W-1:0] out_data;
  logic [LEN_W-1:0]  len_eff, len_m1;
  logic              kpos_last, key_in_range;

  // effective key length, clamped to 1..MAX_KEY_LEN
  always_comb begin
    if (key_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_len_q > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = key_len_q;
    end
  end

  assign len_m1       = len_eff - LEN_W'(1);
  assign kpos_last    = (LEN_W'(kpos_q) == len_m1);
  assign key_in_range = (LEN_W'(key_index_i) < MaxLen);
  assign out_free     = !out_valid_q || !out_stall_i;

  always_comb begin
    pa_re    = 1'b0;
    pa_addr  = '0;
    pb_re    = 1'b0;
    pb_addr  = '0;
    pw_en    = 1'b0;
    pw_addr  = '0;
    pw_data  = '0;
    jn       = '0;
    t        = '0;
    ks       = rd_a_q;
    out_load = 1'b0;
    out_data = data_q;
    out_nk   = 1'b0;
    unique case (op_i)
      OP_FILL: begin
        pw_en   = 1'b1;
        pw_addr = k_q;
        pw_data = k_q;
      end
      OP_KS_RD: begin
        pa_re   = 1'b1;
        pa_addr = k_q;
      end
      OP_KS_J: begin
        jn      = j_q + rd_a_q + key_rd_q;
        pb_re   = 1'b1;
        pb_addr = jn;
      end
      OP_KS_WK: begin
        pw_en   = 1'b1;
        pw_addr = k_q;
        pw_data = rd_b_q;
      end
      OP_KS_WJ: begin
        pw_en   = 1'b1;
        pw_addr = j_q;
        pw_data = s_q;
      end
      OP_D_RI: begin
        pa_re   = 1'b1;
        pa_addr = i_q + PermAw'(1);
      end
      OP_D_J: begin
        jn      = j_q + rd_a_q;
        pb_re   = 1'b1;
        pb_addr = jn;
      end
      OP_D_K: begin
        pw_en   = 1'b1;
        pw_addr = i_q;
        pw_data = rd_b_q;
        t       = s_q + rd_b_q;
        pa_re   = 1'b1;
        pa_addr = t;
      end
      OP_D_W: begin
        pw_en   = 1'b1;
        pw_addr = j_q;
        pw_data = s_q;
        // keystream read saw the table before the swap, forward the swapped pair
        if (t_q == i_q) begin
          ks = sj_q;
        end else if (t_q == j_q) begin
          ks = s_q;
        end else begin
          ks = rd_a_q;
        end
        out_load = 1'b1;
        out_data = data_q ^ ks;
      end
      OP_PASS_OUT: begin
        out_load = 1'b1;
        out_nk   = 1'b1;
      end
      default: ;
    endcase
  end

  // permutation table, one write and two reads, read-first
  always_ff @(posedge clk_i) begin
    if (pw_en) perm_mem[pw_addr] <= pw_data;
    if (pa_re) rd_a_q <= perm_mem[pa_addr];
    if (pb_re) rd_b_q <= perm_mem[pb_addr];
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (op_i == OP_KEY_WR && key_in_range) key_mem[key_index_i[KeyAw-1:0]] <= byte_in_i;
    if (op_i == OP_KS_RD) key_rd_q <= key_mem[kpos_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_D_RI || op_i == OP_PASS_LATCH) data_q <= byte_in_i;
    if (op_i == OP_KS_J || op_i == OP_D_J) s_q <= rd_a_q;
    if (op_i == OP_D_K) begin
      sj_q <= rd_b_q;
      t_q  <= t;
    end
    if (out_load) begin
      byte_out_q  <= out_data;
      not_keyed_q <= out_nk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q   <= LEN_W'(1);
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      kpos_q      <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) key_len_q <= cfg_wdata_i;
      case (op_i)
        OP_SCHED_START: begin
          k_q    <= '0;
          kpos_q <= '0;
          j_q    <= '0;
        end
        OP_FILL: k_q <= k_q + PermAw'(1);
        OP_KS_J: j_q <= jn;
        OP_KS_WJ: begin
          k_q    <= k_q + PermAw'(1);
          kpos_q <= kpos_last ? '0 : kpos_q + KeyAw'(1);
          if (k_q == LastK) begin
            i_q     <= '0;
            j_q     <= '0;
            keyed_q <= 1'b1;
          end
        end
        OP_D_J: begin
          i_q <= i_q + PermAw'(1);
          j_q <= jn;
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.keyed    = keyed_q;
  assign sts_o.k_last   = (k_q == LastK);
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = byte_out_q;
  assign not_keyed_o = not_keyed_q;

  `RC4_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_q || !out_stall_i, "result register overwritten while stalled")
  `RC4_ASSERT_NXT(a_keyed_sticky, keyed_q, keyed_q, "keyed flag dropped")
  `RC4_ASSERT_NXT(a_sched_clears_idx, op_i == OP_KS_WJ && k_q == LastK, i_q == '0 && j_q == '0 && keyed_q, "indices not cleared at end of key schedule")

endmodule

### design/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4 stream cipher
// byte-wide rc4 encrypt/decrypt engine with key store and key schedule
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A key write (func 0) is stored as it is
// accepted and does not stall the channel. A begin-message request (func 1)
// runs the key schedule: an identity fill of the permutation, then 256 swap
// steps that each read S[k] and the key byte, read S[j], write S[k] and write
// S[j]. A keyed data byte (func 2) is accepted as S[i] is read, then reads
// S[j], writes S[i] while reading the keystream entry, and writes S[j] as the
// result is loaded; the single write port of the permutation memory and its
// registered reads put the two dependent reads and the two writes of a swap
// in sequence. A byte sent before any schedule is latched and passes through
// unchanged with not_keyed set. Both wait in their last step for a free output.
// key_length (cfg_wdata_i) is clamped to 1..MAX_KEY_LEN and, like key bytes,
// is only used by the next key schedule. Key bytes at or above MAX_KEY_LEN
// are dropped; a schedule must not read a key byte that was never written.
// The configuration register may only be written while the block is idle.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // key length register
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::LEN_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rc4_pkg::FUNC_W-1:0]    func_i,
  input  logic [rc4_pkg::BYTE_W-1:0]    key_index_i,
  input  logic [rc4_pkg::BYTE_W-1:0]    byte_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rc4_pkg::BYTE_W-1:0]    byte_out_o,
  output logic                          not_keyed_o
);
  import rc4_pkg::*;

  rc4_op_e     op;   // datapath operation for this cycle
  rc4_status_t sts;  // datapath status back to the controller

  // sequencer: one operation per cycle, stalls input while busy
  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  // memories, indices and the output register that decouples the result side
  rc4_datapath #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op),
    .key_index_i (key_index_i),
    .byte_in_i   (byte_in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .byte_out_o  (byte_out_o),
    .not_keyed_o (not_keyed_o),
    .sts_o       (sts)
  );

endmodule

### tb/tb_rc4_stream_cipher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc4 stream cipher testbench
// drives key writes, key schedules, data bytes and unused codes through the
// request channel under random idling on both sides, predicts every result
// with an independent rc4 model and checks each field of each result in order
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RST_CYCLES    = 8;
  // a key schedule runs with no result to show for it
  localparam int SETTLE_CYCLES = 1400;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // long output hold-off, started once after this many results
  localparam int HOLD_CYCLES   = 600;
  localparam int HOLD_AFTER    = 150;
  // the one function code the block ignores
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] key_index;
    logic [BYTE_W-1:0] data;
  } cipher_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              not_keyed;
  } cipher_out_t;

  // dut ports
  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LEN_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [FUNC_W-1:0] func_i;
  logic [BYTE_W-1:0] key_index_i;
  logic [BYTE_W-1:0] byte_in_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] byte_out_o;
  logic              not_keyed_o;

  // cipher state as the predictor sees it
  logic [BYTE_W-1:0] sbox [PERM_DEPTH];
  logic [BYTE_W-1:0] key_bytes [PERM_DEPTH];
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic              sbox_ready;
  logic [LEN_W-1:0]  key_len_reg;
  cipher_out_t       cipher_out_q [$];

  // request generation bookkeeping
  cipher_req_t       pending_req_q [$];
  cipher_req_t       cur_req;
  logic              key_written [PERM_DEPTH];
  int                gen_len;
  int                gen_items;
  int                queued_cnt;
  int                taken_cnt;
  bit                req_taken;

  // idling, hold-off and run status
  int                snd_idle_pct;
  int                rcv_idle_pct;
  int                hold_left;
  bit                hold_done;
  int                results_seen;
  int                err_cnt;
  int                cycle_cnt;

  rc4_stream_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .key_index_i (key_index_i),
    .byte_in_i   (byte_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .byte_out_o  (byte_out_o),
    .not_keyed_o (not_keyed_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // key length as the block uses it: zero acts as one, large values saturate
  function automatic int clamp_key_len(logic [LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_KEY_LEN_DEF) return MAX_KEY_LEN_DEF;
    return int'(v);
  endfunction

  // identity fill, then 256 key-driven swaps; restarts the keystream
  task automatic run_key_schedule();
    int              len;
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] t;
    len = clamp_key_len(key_len_reg);
    for (int k = 0; k < PERM_DEPTH; k++) sbox[k] = BYTE_W'(k);
    j = '0;
    for (int k = 0; k < PERM_DEPTH; k++) begin
      j = j + sbox[k] + key_bytes[k % len];
      t = sbox[k];
      sbox[k] = sbox[j];
      sbox[j] = t;
    end
    idx_i = '0;
    idx_j = '0;
    sbox_ready = 1'b1;
  endtask

  // advance the cipher by one accepted request and queue its result, if any
  task automatic cipher_apply(cipher_req_t req);
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] ks_idx;
    cipher_out_t       res;
    case (req.func)
      FUNC_KEY:   key_bytes[req.key_index] = req.data;
      FUNC_BEGIN: run_key_schedule();
      FUNC_DATA: begin
        if (!sbox_ready) begin
          // no schedule yet: byte passes straight through
          res.byte_out  = req.data;
          res.not_keyed = 1'b1;
        end else begin
          idx_i = idx_i + 8'd1;
          idx_j = idx_j + sbox[idx_i];
          t = sbox[idx_i];
          sbox[idx_i] = sbox[idx_j];
          sbox[idx_j] = t;
          ks_idx = sbox[idx_i] + sbox[idx_j];
          res.byte_out  = req.data ^ sbox[ks_idx];
          res.not_keyed = 1'b0;
        end
        cipher_out_q.push_back(res);
      end
      default: ;  // unused code leaves everything alone
    endcase
  endtask

  task automatic push_req(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] idx,
                          logic [BYTE_W-1:0] data);
    cipher_req_t r;
    r.func      = func;
    r.key_index = idx;
    r.data      = data;
    pending_req_q.push_back(r);
    queued_cnt++;
    if (func == FUNC_KEY) key_written[idx] = 1'b1;
    if (func != FUNC_UNUSED) gen_items++;
  endtask

  // a schedule may only read key bytes that were written, so fill gaps first
  task automatic push_begin();
    for (int k = 0; k < gen_len; k++)
      if (!key_written[k]) push_req(FUNC_KEY, BYTE_W'(k), BYTE_W'($urandom));
    push_req(FUNC_BEGIN, BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic push_data(int n);
    repeat (n) push_req(FUNC_DATA, BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  // mostly complete messages (key update, begin, data), the rest noise
  task automatic gen_traffic(int n);
    int target;
    int pick;
    target = gen_items + n;
    // bytes right after a length change still use the previous schedule
    push_data($urandom_range(1, 3));
    while (gen_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        repeat ($urandom_range(0, 4))
          push_req(FUNC_KEY, BYTE_W'($urandom_range(0, gen_len - 1)), BYTE_W'($urandom));
        push_begin();
        push_data($urandom_range(0, 32));
      end else if (pick < 85) begin
        push_data($urandom_range(1, 8));
      end else if (pick < 93) begin
        push_req(FUNC_KEY, BYTE_W'($urandom), BYTE_W'($urandom));
      end else begin
        push_req(FUNC_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (taken_cnt != queued_cnt || cipher_out_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write only once the block has gone quiet
  task automatic write_key_len(logic [LEN_W-1:0] v);
    wait_drained();
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    key_len_reg = v;
    gen_len     = clamp_key_len(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request driver: a new request only once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      req_taken = 1'b0;
      if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        cur_req = pending_req_q.pop_front();
        in_valid_i  <= 1'b1;
        func_i      <= cur_req.func;
        key_index_i <= cur_req.key_index;
        byte_in_i   <= cur_req.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stall: random, plus one long hold-off so the block backs up
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // request acceptance, result checking and the run limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("%0t: run limit reached", $time);
        $display("tb_rc4_stream_cipher: FAIL");
        $finish;
      end else begin
        if (in_valid_i && !in_stall_o) begin
          cipher_apply(cur_req);
          req_taken = 1'b1;
          taken_cnt++;
        end
        if (out_valid_o && !out_stall_i) begin
          if (cipher_out_q.size() == 0) begin
            err_cnt++;
            $display("%0t: result with nothing expected, byte_out %02h not_keyed %0b",
                     $time, byte_out_o, not_keyed_o);
          end else begin
            cipher_out_t exp_res;
            exp_res = cipher_out_q.pop_front();
            if (byte_out_o !== exp_res.byte_out) begin
              err_cnt++;
              $display("%0t: byte_out expected %02h actual %02h",
                       $time, exp_res.byte_out, byte_out_o);
            end
            if (not_keyed_o !== exp_res.not_keyed) begin
              err_cnt++;
              $display("%0t: not_keyed expected %0b actual %0b",
                       $time, exp_res.not_keyed, not_keyed_o);
            end
          end
          results_seen++;
        end
      end
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_KEY;
    key_index_i = '0;
    byte_in_i   = '0;
    out_stall_i = 1'b0;
    for (int k = 0; k < PERM_DEPTH; k++) begin
      sbox[k]        = BYTE_W'(k);
      key_bytes[k]   = '0;
      key_written[k] = 1'b0;
    end
    idx_i        = '0;
    idx_j        = '0;
    sbox_ready   = 1'b0;
    key_len_reg  = 9'd1;
    gen_len      = 1;
    gen_items    = 0;
    queued_cnt   = 0;
    taken_cnt    = 0;
    req_taken    = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    results_seen = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    // sender idles less than the receiver first
    snd_idle_pct = 30;
    rcv_idle_pct = 70;

    repeat (RST_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: pass-through before any schedule, field extremes, the unused
    // code, key writes that only count at the next begin, and a rekey
    push_req(FUNC_DATA, 8'h00, 8'h00);
    push_req(FUNC_DATA, 8'hFF, 8'hFF);
    push_req(FUNC_UNUSED, 8'h00, 8'h00);
    push_req(FUNC_KEY, 8'hFF, 8'hFF);
    push_req(FUNC_KEY, 8'h00, 8'h00);
    push_req(FUNC_BEGIN, 8'h00, 8'h00);
    push_req(FUNC_DATA, 8'h00, 8'h00);
    push_req(FUNC_DATA, 8'hFF, 8'hFF);
    push_req(FUNC_DATA, 8'h5A, 8'h5A);
    push_req(FUNC_UNUSED, 8'hFF, 8'hFF);
    push_req(FUNC_KEY, 8'h00, 8'hFF);
    push_req(FUNC_DATA, 8'hA5, 8'hA5);
    push_req(FUNC_BEGIN, 8'hFF, 8'hFF);
    push_data(4);

    // zero length acts as one, then the longest key
    write_key_len(9'd0);
    gen_traffic(220);
    write_key_len(9'd256);
    gen_traffic(300);

    // receiver idles less than the sender now
    write_key_len(9'd511);
    snd_idle_pct = 70;
    rcv_idle_pct = 30;
    gen_traffic(150);
    write_key_len(9'd1);
    gen_traffic(100);
    // sender holds back until every result is in
    wait_drained();
    gen_traffic(100);
    write_key_len(9'd2);
    gen_traffic(200);

    // no idling on either side
    write_key_len(LEN_W'($urandom_range(3, 255)));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    gen_traffic(250);
    write_key_len(LEN_W'($urandom_range(257, 510)));
    gen_traffic(150);
    write_key_len(9'd255);
    gen_traffic(200);

    // let any trailing schedule finish so stray results would show up
    wait_drained();
    settle();
    if (err_cnt == 0) begin
      $display("tb_rc4_stream_cipher: PASS");
    end else begin
      $display("tb_rc4_stream_cipher: FAIL");
    end
    $finish;
  end

endmodule

### rc4_stream_cipher.f
+incdir+design
design/rc4_pkg.sv
design/rc4_ctrl.sv
design/rc4_datapath.sv
design/rc4_stream_cipher.sv
tb/tb_rc4_stream_cipher.sv
